FILE: hdl/u16u8_pkg.sv
// Package for the UTF-16 to UTF-8 encoder: item and job types, queue depth,
// and the byte builder used by the back emitter.
// No dependencies.
`default_nettype none

package u16u8_pkg;

    // Default depth of the job queue between front and back (power of two, >= 2)
    localparam int QUEUE_DEPTH = 4;

    // One input item
    typedef struct packed {
        logic [15:0] code_unit;
        logic        string_end;
    } t_in_item;

    // One result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_item;
        logic       lone_surrogate;
    } t_out_item;

    // Main encoding form of a job
    typedef enum logic [2:0] {
        K_NONE,
        K_ONE,
        K_TWO,
        K_THREE,
        K_PAIR
    } t_kind;

    // Work descriptor handed from front to back
    typedef struct packed {
        logic        pre_lone;   // emit held high surrogate as flagged 3-byte form first
        logic [9:0]  pre_low10;  // low 10 bits of that held surrogate
        t_kind       kind;       // main encoding form
        logic        main_lone;  // main bytes belong to an unpaired surrogate
        logic [20:0] data;       // code unit, or code point for a pair
    } t_job;

    // Number of bytes of the main part
    function automatic logic [2:0] f_main_count(t_kind kind);
        logic [2:0] cnt;
        unique case (kind)
            K_ONE:   cnt = 3'd1;
            K_TWO:   cnt = 3'd2;
            K_THREE: cnt = 3'd3;
            K_PAIR:  cnt = 3'd4;
            default: cnt = 3'd0;
        endcase
        return cnt;
    endfunction

    // Byte number k of the main part
    function automatic logic [7:0] f_main_byte(t_kind kind, logic [20:0] d, logic [1:0] k);
        logic [7:0] b;
        b = 8'h00;
        unique case (kind)
            K_ONE: begin
                b = {1'b0, d[6:0]};
            end
            K_TWO: begin
                b = (k == 2'd0) ? {3'b110, d[10:6]} : {2'b10, d[5:0]};
            end
            K_THREE: begin
                case (k)
                    2'd0:    b = {4'b1110, d[15:12]};
                    2'd1:    b = {2'b10, d[11:6]};
                    default: b = {2'b10, d[5:0]};
                endcase
            end
            K_PAIR: begin
                case (k)
                    2'd0:    b = {5'b11110, d[20:18]};
                    2'd1:    b = {2'b10, d[17:12]};
                    2'd2:    b = {2'b10, d[11:6]};
                    default: b = {2'b10, d[5:0]};
                endcase
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/u16u8_front.sv
// Front classifier of the UTF-16 to UTF-8 encoder: accepts code units,
// tracks a held high surrogate and builds one job per item that makes bytes.
// Depends on u16u8_pkg.
`default_nettype none

module u16u8_front
    import u16u8_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_stall,
    input  wire t_in_item i_item,
    input  wire logic     i_full,
    output logic          o_push,
    output t_job          o_job
);

    logic       r_held_valid;
    logic [9:0] r_held_low;
    logic       n_held_valid;
    logic [9:0] n_held_low;

    logic        w_accept;
    logic [15:0] w_u;
    logic        w_is_high;
    logic        w_is_low;
    logic [20:0] w_cp;

    assign w_u       = i_item.code_unit;
    assign w_is_high = (w_u[15:10] == 6'b110110);
    assign w_is_low  = (w_u[15:10] == 6'b110111);
    assign w_cp      = 21'h10000 + {1'b0, r_held_low, w_u[9:0]};

    // Stall while the job queue has no room
    assign o_stall  = i_full;
    assign w_accept = i_valid && !i_full;

    // Classify the unit against the held surrogate
    always_comb begin
        o_job        = '0;
        o_job.kind   = K_NONE;
        n_held_valid = r_held_valid;
        n_held_low   = r_held_low;
        if (r_held_valid && w_is_low) begin
            o_job.kind   = K_PAIR;
            o_job.data   = w_cp;
            n_held_valid = 1'b0;
            n_held_low   = '0;
        end else begin
            o_job.pre_lone  = r_held_valid;
            o_job.pre_low10 = r_held_low;
            o_job.data      = {5'b0, w_u};
            n_held_valid    = 1'b0;
            n_held_low      = '0;
            if (w_u[15:7] == 9'd0) begin
                o_job.kind = K_ONE;
            end else if (w_u[15:11] == 5'd0) begin
                o_job.kind = K_TWO;
            end else if (w_is_high) begin
                if (i_item.string_end) begin
                    o_job.kind      = K_THREE;
                    o_job.main_lone = 1'b1;
                end else begin
                    n_held_valid = 1'b1;
                    n_held_low   = w_u[9:0];
                end
            end else begin
                o_job.kind      = K_THREE;
                o_job.main_lone = w_is_low;
            end
        end
    end

    // Queue a job only when the item makes bytes
    assign o_push = w_accept && (o_job.pre_lone || (o_job.kind != K_NONE));

    // Held surrogate state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_held_low   <= '0;
        end else if (w_accept) begin
            r_held_valid <= n_held_valid;
            r_held_low   <= n_held_low;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/u16u8_fifo.sv
// Short show-ahead job queue between front and back of the encoder.
// Depends on u16u8_pkg.
`default_nettype none

module u16u8_fifo
    import u16u8_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output t_job      o_job,
    output logic      o_full,
    output logic      o_empty
);

    localparam int AW = $clog2(DEPTH);

    t_job          r_slot [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [AW:0]   r_count;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_slot[r_rd_ptr];

    // Store pushed jobs
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/u16u8_back.sv
// Back emitter of the UTF-16 to UTF-8 encoder: walks the head job one byte
// per cycle into an output register while not stalled. Depends on u16u8_pkg.
`default_nettype none

module u16u8_back
    import u16u8_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_job i_job,
    input  wire logic i_empty,
    output logic      o_pop,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_out_item o_item
);

    logic      r_valid;
    t_out_item r_item;
    logic [2:0] r_idx;

    logic       w_adv;
    logic       w_take;
    logic [2:0] w_total;
    logic       w_in_pre;
    logic [2:0] w_off;
    logic       w_last;
    t_out_item  n_item;

    // Byte count and position within the job
    assign w_total  = (i_job.pre_lone ? 3'd3 : 3'd0) + f_main_count(i_job.kind);
    assign w_in_pre = i_job.pre_lone && (r_idx < 3'd3);
    assign w_off    = i_job.pre_lone ? (r_idx - 3'd3) : r_idx;
    assign w_last   = (r_idx == (w_total - 3'd1));

    // Build the current byte
    always_comb begin
        n_item = '0;
        if (w_in_pre) begin
            n_item.out_byte = f_main_byte(K_THREE, {5'b0, 6'b110110, i_job.pre_low10},
                                          r_idx[1:0]);
            n_item.lone_surrogate = 1'b1;
        end else begin
            n_item.out_byte       = f_main_byte(i_job.kind, i_job.data, w_off[1:0]);
            n_item.lone_surrogate = i_job.main_lone;
        end
        n_item.last_of_item = w_last;
    end

    // Load the output register whenever it is free or being drained
    assign w_adv  = !r_valid || !i_stall;
    assign w_take = w_adv && !i_empty;
    assign o_pop  = w_take && w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (w_adv) begin
                r_valid <= !i_empty;
            end
            if (w_take) begin
                r_idx <= w_last ? 3'd0 : (r_idx + 3'd1);
            end
        end
    end

    // Hold payload while stalled
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

FILE: hdl/utf16_to_utf8_encoder_core.sv
// UTF-16 to UTF-8 encoder, top level.
// Input channel: i_valid / o_stall / i_item carry one UTF-16 code unit and an
// end-of-string mark per transfer. Output channel: o_valid / i_stall / o_item
// carry one UTF-8 byte per transfer, with a last-byte-of-item mark and a flag
// for bytes of an unpaired surrogate's 3-byte form.
// A high surrogate is held until the next unit; a following low surrogate
// makes one 4-byte sequence, anything else flushes it as a flagged 3-byte
// form first. A high surrogate arriving with the end mark is not held.
// With the queue empty and the output register free, a transferred item's
// job is written into the queue, and its first byte is then loaded into the
// output register. Throughput: one output byte per cycle while the output is
// not stalled, set by the single byte lane of the back emitter; an item makes
// 0 to 6 bytes (normally 1 to 4), and items producing no byte queue no job.
// The front accepts a unit every cycle while the job queue (QDEPTH entries)
// has room; o_stall rises when it is full.
// A stall on the output holds the byte register and backs up the queue; the
// front keeps taking items until the queue fills.
// Reset (synchronous, active low) empties the queue and the output register
// and drops any held surrogate.
// Depends on u16u8_pkg, u16u8_front, u16u8_fifo, u16u8_back.
`default_nettype none

module utf16_to_utf8_encoder_core
    import u16u8_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_stall,
    input  wire t_in_item i_item,
    output logic          o_valid,
    input  wire logic     i_stall,
    output t_out_item     o_item
);

    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;
    t_job w_job_in;
    t_job w_job_out;

    u16u8_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_job_in)
    );

    u16u8_fifo #(
        .DEPTH (QDEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_job   (w_job_out),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    u16u8_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (w_job_out),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    // Never push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("job pushed into full queue");

    // Never pop an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("job popped from empty queue");

    // A push without a pop leaves work queued
    a_push_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> !w_empty)
        else $error("pushed job lost");

    // A popped job's last byte enters the output register
    a_pop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> (o_valid && o_item.last_of_item))
        else $error("job retired without final byte");

endmodule

`default_nettype wire
